// File: hdl/dmaq_pkg.sv
// shared types and constants of the dma descriptor queue
`timescale 1ns / 1ps

package dmaq_pkg;

  localparam int DEF_NUM_CHANNELS = 8;
  localparam int DEF_QUEUE_DEPTH  = 16;

  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 12;
  localparam int CHAN_W      = 3;
  localparam int BITMAP_W    = 8;
  localparam int CFG_CHAN_W  = 4;
  localparam int CFG_SLOTS_W = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int S_TDATA_W   = 88;
  localparam int M_TDATA_W   = 80;
  localparam int M_TUSER_W   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_SLOTS_IN_USE = 1'b1;

  typedef enum logic {
    OP_REQUEST  = 1'b0,
    OP_COMPLETE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    RING_NOP,
    RING_LAUNCH,
    RING_PUSH,
    RING_POP,
    RING_STOP
  } ring_op_e;

  typedef struct packed {
    logic busy;
    logic empty;
    logic full;
  } ring_status_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
  } desc_t;

endpackage

// File: hdl/dma_descriptor_queue.sv
// top level of the multi-channel dma descriptor queue
`timescale 1ns / 1ps

// Keeps a ring of transfer descriptors and a busy flag for each DMA channel.
// A request word (tuser 0) starts its channel when idle, is queued when the
// channel is busy, and is rejected when the ring is full or the channel is not
// in use; it gives one result word. A completion word (tuser 1) gives one result
// word per set bitmap bit below channels_in_use, in channel order, each launching
// the next queued descriptor or idling the channel; tlast marks the final one,
// and a bitmap with no such bit gives no result. One item is handled at a time:
// a request is decided, then its result is registered and held until taken; a
// completion scans its channels in order, registering and holding a result for
// each set bit, and scans at most 8 channels. The rate is set by the sequencer
// stepping channels one at a time through the shared ring pointer unit and the
// single-port descriptor memory.
// Configuration writes are always ready and must only be made while idle.

module dma_descriptor_queue import dmaq_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // channel, src_addr, dst_addr, transfer_size, completion_bits, zero pad
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // launch_channel, launch_src, launch_dst, launch_size, zero pad
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // launch, accepted, queue_full
  output logic [M_TUSER_W-1:0]  m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int ACT_W = 6;
  localparam int SCAN_W = 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REQ  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  logic [2:0] state_q, state_d;

  logic [CFG_CHAN_W-1:0]  chan_cfg_q;
  logic [CFG_SLOTS_W-1:0] slots_cfg_q;

  opcode_e               opcode_q;
  logic [CHAN_W-1:0]     chan_q;
  desc_t                 desc_q;
  logic [BITMAP_W-1:0]   bits_q;
  logic                  load_in;

  logic [SCAN_W-1:0] scan_q, scan_d;
  logic              launch_q, launch_d;
  logic              accepted_q, accepted_d;
  logic              range_err_q, range_err_d;
  logic              last_q, last_d;
  logic              m_valid_q, m_valid_d;
  logic              load_out;

  logic              out_launch_q, out_acc_q, out_full_q, out_last_q;
  logic [CHAN_W-1:0] out_ch_q;
  desc_t             out_desc_q;

  ring_op_e         ring_op;
  ring_status_t     ring_status;
  logic [CH_W-1:0]  ring_sel;
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  desc_t            mem_rdata;
  logic             mem_we, mem_re;

  logic [ACT_W-1:0]    act_chans;
  logic [SCAN_W-1:0]   scan_lim;
  logic [BITMAP_W-1:0] rest_bits;
  logic                in_range;

  // clamp the channel count to 1..NUM_CHANNELS, scan at most the bitmap width
  always_comb begin
    act_chans = ACT_W'(chan_cfg_q);
    if (act_chans < ACT_W'(1)) begin
      act_chans = ACT_W'(1);
    end else if (act_chans > ACT_W'(NUM_CHANNELS)) begin
      act_chans = ACT_W'(NUM_CHANNELS);
    end
    if (act_chans > ACT_W'(BITMAP_W)) begin
      scan_lim = SCAN_W'(BITMAP_W);
    end else begin
      scan_lim = SCAN_W'(act_chans);
    end
  end

  // set bits above the current scan position and below the limit
  always_comb begin
    for (int i = 0; i < BITMAP_W; i++) begin
      rest_bits[i] = bits_q[i] && (SCAN_W'(i) > scan_q) && (SCAN_W'(i) < scan_lim);
    end
  end

  assign in_range = (ACT_W'(chan_q) < act_chans);
  assign ring_sel = (opcode_q == OP_REQUEST) ? CH_W'(chan_q) : CH_W'(scan_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    launch_d    = launch_q;
    accepted_d  = accepted_q;
    range_err_d = range_err_q;
    last_d      = last_q;
    m_valid_d   = m_valid_q;
    ring_op     = RING_NOP;
    load_in     = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          load_in = 1'b1;
          scan_d  = '0;
          state_d = (opcode_e'(s_axis_tuser) == OP_REQUEST) ? S_REQ : S_SCAN;
        end
      end
      S_REQ: begin
        last_d      = 1'b1;
        range_err_d = 1'b0;
        launch_d    = 1'b0;
        accepted_d  = 1'b0;
        if (!in_range) begin
          range_err_d = 1'b1;
        end else if (ring_status.full) begin
          accepted_d = 1'b0;
        end else if (!ring_status.busy) begin
          ring_op    = RING_LAUNCH;
          launch_d   = 1'b1;
          accepted_d = 1'b1;
        end else begin
          ring_op    = RING_PUSH;
          accepted_d = 1'b1;
        end
        state_d = S_EMIT;
      end
      S_SCAN: begin
        if (scan_q >= scan_lim) begin
          state_d = S_IDLE;
        end else if (bits_q[scan_q[2:0]]) begin
          range_err_d = 1'b0;
          accepted_d  = 1'b0;
          last_d      = (rest_bits == '0);
          if (!ring_status.empty) begin
            ring_op  = RING_POP;
            launch_d = 1'b1;
          end else begin
            ring_op  = RING_STOP;
            launch_d = 1'b0;
          end
          state_d = S_EMIT;
        end else begin
          scan_d = scan_q + SCAN_W'(1);
        end
      end
      S_EMIT: begin
        // pointers and read data now reflect this step
        load_out  = 1'b1;
        m_valid_d = 1'b1;
        state_d   = S_HOLD;
      end
      S_HOLD: begin
        if (m_axis_tready) begin
          m_valid_d = 1'b0;
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            scan_d  = scan_q + SCAN_W'(1);
            state_d = S_SCAN;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_we = (ring_op == RING_PUSH);
  assign mem_re = (ring_op == RING_POP);

  dmaq_ring #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .slots_cfg_i(slots_cfg_q),
    .sel_i      (ring_sel),
    .op_i       (ring_op),
    .status_o   (ring_status),
    .wr_ptr_o   (wr_ptr),
    .rd_ptr_o   (rd_ptr)
  );

  dmaq_desc_mem #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_desc_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .ch_i   (ring_sel),
    .ptr_i  (mem_we ? wr_ptr : rd_ptr),
    .wdata_i(desc_q),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chan_cfg_q  <= CFG_CHAN_W'(DEF_NUM_CHANNELS);
      slots_cfg_q <= CFG_SLOTS_W'(DEF_QUEUE_DEPTH);
      opcode_q    <= OP_REQUEST;
      scan_q      <= '0;
      launch_q    <= 1'b0;
      accepted_q  <= 1'b0;
      range_err_q <= 1'b0;
      last_q      <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      launch_q    <= launch_d;
      accepted_q  <= accepted_d;
      range_err_q <= range_err_d;
      last_q      <= last_d;
      m_valid_q   <= m_valid_d;
      if (load_in) begin
        opcode_q <= opcode_e'(s_axis_tuser);
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_CHANNELS_IN_USE:    chan_cfg_q  <= cfg_data_i[CFG_CHAN_W-1:0];
          REG_QUEUE_SLOTS_IN_USE: slots_cfg_q <= cfg_data_i[CFG_SLOTS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      chan_q      <= s_axis_tdata[2:0];
      desc_q.src  <= s_axis_tdata[34:3];
      desc_q.dst  <= s_axis_tdata[66:35];
      desc_q.size <= s_axis_tdata[78:67];
      bits_q      <= s_axis_tdata[86:79];
    end
    if (load_out) begin
      out_launch_q <= launch_q;
      out_ch_q     <= (opcode_q == OP_REQUEST) ? chan_q : scan_q[CHAN_W-1:0];
      if (!launch_q) begin
        out_desc_q <= '0;
      end else if (opcode_q == OP_REQUEST) begin
        out_desc_q <= desc_q;
      end else begin
        out_desc_q <= mem_rdata;
      end
      out_acc_q  <= accepted_q;
      out_full_q <= range_err_q ? 1'b0 : ring_status.full;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, out_desc_q.size, out_desc_q.dst, out_desc_q.src, out_ch_q};
  assign m_axis_tuser  = {out_full_q, out_acc_q, out_launch_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// File: hdl/dmaq_desc_mem.sv
// descriptor memory, one ring of slots per channel, registered read
`timescale 1ns / 1ps

module dmaq_desc_mem import dmaq_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic                                          re_i,
  input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] ch_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]                ptr_i,
  input  desc_t                                         wdata_i,
  output desc_t                                         rdata_o
);

  localparam int DEPTH = NUM_CHANNELS * QUEUE_DEPTH;
  localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  desc_t             mem_q [DEPTH];
  desc_t             rdata_q;
  logic [MEM_AW-1:0] addr;

  assign addr = MEM_AW'(ch_i) * MEM_AW'(QUEUE_DEPTH) + MEM_AW'(ptr_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/dmaq_ring.sv
// per-channel ring pointers and busy flags with one shared advance and compare unit
`timescale 1ns / 1ps

module dmaq_ring import dmaq_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [CFG_SLOTS_W-1:0]                        slots_cfg_i,
  input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] sel_i,
  input  ring_op_e                                      op_i,
  output ring_status_t                                  status_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]                wr_ptr_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]                rd_ptr_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int SW    = (PTR_W + 1 > CFG_SLOTS_W) ? PTR_W + 1 : CFG_SLOTS_W;

  logic [PTR_W-1:0]        wr_ptr_q [NUM_CHANNELS];
  logic [PTR_W-1:0]        rd_ptr_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] busy_q;

  logic [SW-1:0]    slots;
  logic [PTR_W-1:0] wr_cur, rd_cur, wr_nxt, rd_nxt;

  // clamp the slot count to 2..QUEUE_DEPTH
  always_comb begin
    slots = SW'(slots_cfg_i);
    if (slots < SW'(2)) begin
      slots = SW'(2);
    end else if (slots > SW'(QUEUE_DEPTH)) begin
      slots = SW'(QUEUE_DEPTH);
    end
  end

  assign wr_cur = wr_ptr_q[sel_i];
  assign rd_cur = rd_ptr_q[sel_i];

  // wrap at the slot count; pointers left above it after a shrink wrap too
  assign wr_nxt = (SW'(wr_cur) + SW'(1) >= slots) ? '0 : wr_cur + PTR_W'(1);
  assign rd_nxt = (SW'(rd_cur) + SW'(1) >= slots) ? '0 : rd_cur + PTR_W'(1);

  assign status_o.busy  = busy_q[sel_i];
  assign status_o.empty = (wr_cur == rd_cur);
  assign status_o.full  = (wr_nxt == rd_cur);
  assign wr_ptr_o       = wr_cur;
  assign rd_ptr_o       = rd_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wr_ptr_q[i] <= '0;
        rd_ptr_q[i] <= '0;
      end
      busy_q <= '0;
    end else begin
      unique case (op_i)
        RING_LAUNCH: begin
          busy_q[sel_i] <= 1'b1;
        end
        RING_PUSH: begin
          wr_ptr_q[sel_i] <= wr_nxt;
        end
        RING_POP: begin
          rd_ptr_q[sel_i] <= rd_nxt;
          busy_q[sel_i]   <= 1'b1;
        end
        RING_STOP: begin
          busy_q[sel_i] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: tb/dmaq_launch_checker.sv
// launch word predictor and comparator for the dma descriptor queue testbench
`timescale 1ns / 1ps

module dmaq_launch_checker import dmaq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [S_TDATA_W-1:0]  s_tdata_i,
  input  logic                  s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [M_TDATA_W-1:0]  m_tdata_i,
  input  logic [M_TUSER_W-1:0]  m_tuser_i,
  input  logic                  m_tlast_i,
  output int                    word_errors_o,
  output int                    reports_due_o,
  output logic                  rings_hold_o
);

  localparam int PTR_W = $clog2(DEF_QUEUE_DEPTH);

  typedef struct packed {
    logic              launch;
    logic [CHAN_W-1:0] chan;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [SIZE_W-1:0] size;
    logic              accepted;
    logic              full;
    logic              last;
  } report_t;

  logic [CFG_CHAN_W-1:0]  chan_reg;
  logic [CFG_SLOTS_W-1:0] slot_reg;
  logic [PTR_W-1:0]       wr_ptr   [DEF_NUM_CHANNELS];
  logic [PTR_W-1:0]       rd_ptr   [DEF_NUM_CHANNELS];
  logic                   busy     [DEF_NUM_CHANNELS];
  logic [ADDR_W-1:0]      src_ring [DEF_NUM_CHANNELS][DEF_QUEUE_DEPTH];
  logic [ADDR_W-1:0]      dst_ring [DEF_NUM_CHANNELS][DEF_QUEUE_DEPTH];
  logic [SIZE_W-1:0]      len_ring [DEF_NUM_CHANNELS][DEF_QUEUE_DEPTH];
  report_t                reports_due [$];

  function automatic int live_channels();
    if (chan_reg < 1) return 1;
    if (chan_reg > DEF_NUM_CHANNELS) return DEF_NUM_CHANNELS;
    return int'(chan_reg);
  endfunction

  function automatic int live_slots();
    if (slot_reg < 2) return 2;
    if (slot_reg > DEF_QUEUE_DEPTH) return DEF_QUEUE_DEPTH;
    return int'(slot_reg);
  endfunction

  // a pointer left above the slot count by a shrink wraps to zero on its next step
  function automatic logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
    return (int'(p) + 1 >= live_slots()) ? '0 : p + 1'b1;
  endfunction

  function automatic logic ring_full(int ch);
    return step_ptr(wr_ptr[ch]) == rd_ptr[ch];
  endfunction

  function automatic string describe(report_t r);
    return $sformatf("launch=%0b ch=%0d src=%08h dst=%08h size=%03h acc=%0b full=%0b last=%0b",
                     r.launch, r.chan, r.src, r.dst, r.size, r.accepted, r.full, r.last);
  endfunction

  task automatic predict_word(opcode_e op, logic [S_TDATA_W-1:0] word);
    logic [CHAN_W-1:0]   chan;
    logic [ADDR_W-1:0]   src;
    logic [ADDR_W-1:0]   dst;
    logic [SIZE_W-1:0]   size;
    logic [BITMAP_W-1:0] bitmap;
    report_t             r;
    report_t             held;
    bit                  have;
    chan   = word[2:0];
    src    = word[34:3];
    dst    = word[66:35];
    size   = word[78:67];
    bitmap = word[86:79];
    if (op == OP_REQUEST) begin
      r      = '0;
      r.chan = chan;
      r.last = 1'b1;
      if (int'(chan) >= live_channels()) begin
        // channel not in use: plain reject
      end else if (ring_full(chan)) begin
        r.full = 1'b1;
      end else if (!busy[chan]) begin
        busy[chan] = 1'b1;
        r.launch   = 1'b1;
        r.src      = src;
        r.dst      = dst;
        r.size     = size;
        r.accepted = 1'b1;
        r.full     = ring_full(chan);
      end else begin
        src_ring[chan][wr_ptr[chan]] = src;
        dst_ring[chan][wr_ptr[chan]] = dst;
        len_ring[chan][wr_ptr[chan]] = size;
        wr_ptr[chan] = step_ptr(wr_ptr[chan]);
        r.accepted   = 1'b1;
        r.full       = ring_full(chan);
      end
      reports_due.push_back(r);
    end else begin
      have = 1'b0;
      held = '0;
      for (int ch = 0; ch < live_channels(); ch++) begin
        if (bitmap[ch]) begin
          if (have) reports_due.push_back(held);
          r      = '0;
          r.chan = CHAN_W'(ch);
          if (wr_ptr[ch] != rd_ptr[ch]) begin
            r.launch   = 1'b1;
            r.src      = src_ring[ch][rd_ptr[ch]];
            r.dst      = dst_ring[ch][rd_ptr[ch]];
            r.size     = len_ring[ch][rd_ptr[ch]];
            rd_ptr[ch] = step_ptr(rd_ptr[ch]);
            busy[ch]   = 1'b1;
          end else begin
            busy[ch] = 1'b0;
          end
          r.full = ring_full(ch);
          held   = r;
          have   = 1'b1;
        end
      end
      if (have) begin
        held.last = 1'b1;
        reports_due.push_back(held);
      end
    end
  endtask

  task automatic check_word(report_t got);
    report_t want;
    string   bad;
    bad  = "";
    want = '0;
    if (reports_due.size() == 0) begin
      bad = " unexpected";
    end else begin
      want = reports_due.pop_front();
      if (got.launch !== want.launch) bad = {bad, " launch"};
      if (got.chan !== want.chan) bad = {bad, " channel"};
      if (got.src !== want.src) bad = {bad, " src"};
      if (got.dst !== want.dst) bad = {bad, " dst"};
      if (got.size !== want.size) bad = {bad, " size"};
      if (got.accepted !== want.accepted) bad = {bad, " accepted"};
      if (got.full !== want.full) bad = {bad, " queue_full"};
      if (got.last !== want.last) bad = {bad, " last"};
    end
    if (bad != "") begin
      word_errors_o++;
      if (word_errors_o <= 10) begin
        $display("launch word mismatch:%s", bad);
        $display("  exp %s", describe(want));
        $display("  got %s", describe(got));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t got;
    if (!rst_ni) begin
      chan_reg = CFG_CHAN_W'(DEF_NUM_CHANNELS);
      slot_reg = CFG_SLOTS_W'(DEF_QUEUE_DEPTH);
      for (int c = 0; c < DEF_NUM_CHANNELS; c++) begin
        wr_ptr[c] = '0;
        rd_ptr[c] = '0;
        busy[c]   = 1'b0;
      end
      reports_due.delete();
      word_errors_o = 0;
      reports_due_o = 0;
      rings_hold_o  = 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_CHANNELS_IN_USE) chan_reg = cfg_data_i[CFG_CHAN_W-1:0];
        else slot_reg = cfg_data_i[CFG_SLOTS_W-1:0];
      end
      if (s_tvalid_i && s_tready_i) predict_word(opcode_e'(s_tuser_i), s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        got.chan     = m_tdata_i[2:0];
        got.src      = m_tdata_i[34:3];
        got.dst      = m_tdata_i[66:35];
        got.size     = m_tdata_i[78:67];
        got.launch   = m_tuser_i[0];
        got.accepted = m_tuser_i[1];
        got.full     = m_tuser_i[2];
        got.last     = m_tlast_i;
        check_word(got);
      end
      reports_due_o = reports_due.size();
      rings_hold_o  = 1'b0;
      for (int c = 0; c < DEF_NUM_CHANNELS; c++) begin
        if (wr_ptr[c] != rd_ptr[c]) rings_hold_o = 1'b1;
      end
    end
  end

endmodule

// File: tb/tb_dma_descriptor_queue.sv
// testbench top: stimulus, stalls, watchdog and verdict for the dma descriptor queue
`timescale 1ns / 1ps

module tb_dma_descriptor_queue;
  import dmaq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 230;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  m_axis_tlast;

  int   word_errors;
  int   reports_due;
  logic rings_hold;

  bit   tx_calm;
  bit   rx_calm;
  int   live_ch;
  logic [CFG_DATA_W-1:0] slot_setting;

  dma_descriptor_queue dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  dmaq_launch_checker u_launch_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .m_tlast_i     (m_axis_tlast),
    .word_errors_o (word_errors),
    .reports_due_o (reports_due),
    .rings_hold_o  (rings_hold)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [S_TDATA_W-1:0] pack_word(logic [2:0] ch, logic [31:0] src,
                                                     logic [31:0] dst, logic [11:0] size,
                                                     logic [7:0] bits);
    return {1'b0, bits, size, dst, src, ch};
  endfunction

  task automatic send_word(opcode_e op, logic [S_TDATA_W-1:0] word);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic request(logic [2:0] ch, logic [31:0] src, logic [31:0] dst,
                         logic [11:0] size);
    send_word(OP_REQUEST, pack_word(ch, src, dst, size, 8'($urandom)));
  endtask

  task automatic complete(logic [7:0] bits);
    send_word(OP_COMPLETE, pack_word(3'($urandom), $urandom, $urandom, 12'($urandom), bits));
  endtask

  // both registers in one burst, valid held high across the two words
  task automatic write_config(logic [CFG_DATA_W-1:0] chans, logic [CFG_DATA_W-1:0] slots);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CHANNELS_IN_USE;
    cfg_data  <= chans;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_QUEUE_SLOTS_IN_USE;
    cfg_data  <= slots;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    live_ch      = (chans[3:0] < 1) ? 1 : (chans[3:0] > 8) ? 8 : int'(chans[3:0]);
    slot_setting = slots;
  endtask

  // hold off input until every launch word is out, then let trailing scans finish
  task automatic wait_for_quiet();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (reports_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // queued descriptors must be popped before the slot count moves
  task automatic retune(logic [CFG_DATA_W-1:0] chans, logic [CFG_DATA_W-1:0] slots);
    wait_for_quiet();
    if (rings_hold) begin
      write_config(5'd8, slot_setting);
      while (rings_hold) begin
        complete(8'hff);
        wait_for_quiet();
      end
    end
    write_config(chans, slots);
  endtask

  task automatic random_item(logic [2:0] hot_ch);
    logic [2:0] ch;
    logic [7:0] bits;
    if ($urandom_range(0, 99) < 58) begin
      if ($urandom_range(0, 9) == 0) ch = 3'($urandom_range(0, 7));
      else if ($urandom_range(0, 9) < 4) ch = hot_ch;
      else ch = 3'($urandom_range(0, live_ch - 1));
      request(ch, $urandom, $urandom, 12'($urandom));
    end else begin
      case ($urandom_range(0, 5))
        0:       bits = 8'hff;
        1:       bits = 8'(1 << $urandom_range(0, 7));
        2:       bits = 8'h00;
        default: bits = 8'($urandom);
      endcase
      complete(bits);
    end
  endtask

  initial begin
    int sent;
    int phase_items;
    logic [2:0] hot_ch;
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_CHANNELS_IN_USE;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_REQUEST;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    live_ch = 8;
    slot_setting = 5'd16;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // fill a small ring, overflow it, then pop it dry
    write_config(5'd8, 5'd4);
    request(3'd0, 32'h0, 32'h0, 12'h000);
    request(3'd0, 32'hffffffff, 32'hffffffff, 12'hfff);
    request(3'd0, 32'haaaaaaaa, 32'h55555555, 12'haaa);
    request(3'd0, 32'h55555555, 32'haaaaaaaa, 12'h555);
    request(3'd0, 32'h12345678, 32'h9abcdef0, 12'h123);
    request(3'd7, 32'hdeadbeef, 32'h0, 12'hfff);
    complete(8'hff);
    complete(8'h00);
    complete(8'h01);
    complete(8'h01);
    complete(8'h01);

    // channel count below range saturates to one, slot count above range to max
    retune(5'd0, 5'd31);
    request(3'd1, 32'h1111_0000, 32'h0000_1111, 12'h0f0);
    request(3'd7, 32'h2222_0000, 32'h0000_2222, 12'h00f);
    request(3'd0, 32'h3333_0000, 32'h0000_3333, 12'hf00);
    complete(8'hfe);
    complete(8'hff);

    // shrink to two slots with ring pointers parked above the new count
    retune(5'd15, 5'd1);
    request(3'd0, 32'h0badf00d, 32'hcafef00d, 12'h321);
    request(3'd0, 32'h01020304, 32'h05060708, 12'h456);
    request(3'd0, 32'h11223344, 32'h55667788, 12'h789);
    request(3'd0, 32'h99aabbcc, 32'hddeeff00, 12'habc);
    complete(8'h01);
    complete(8'h01);
    complete(8'h01);

    sent = 0;
    for (int p = 0; sent < RANDOM_ITEMS; p++) begin
      case (p)
        0:       retune(5'd8, 5'd16);
        1:       retune(5'd1, 5'd2);
        2:       retune(5'd8, 5'd2);
        3:       retune(5'd20, 5'd3);
        4:       retune(5'd4, 5'd16);
        default: retune(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      endcase
      tx_calm     = ($urandom_range(0, 3) == 0);
      rx_calm     = ($urandom_range(0, 3) == 0);
      hot_ch      = 3'($urandom_range(0, live_ch - 1));
      phase_items = $urandom_range(25, 50);
      repeat (phase_items) begin
        random_item(hot_ch);
        sent++;
      end
    end

    wait_for_quiet();
    if (word_errors == 0 && reports_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side: random stall before each word, none during calm stretches
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
hdl/dmaq_pkg.sv
hdl/dmaq_desc_mem.sv
hdl/dmaq_ring.sv
hdl/dma_descriptor_queue.sv
tb/dmaq_launch_checker.sv
tb/tb_dma_descriptor_queue.sv
